// ----- hdl/elp_pkg.sv -----
// Shared types, constants and helper functions of the epoch anchored loop pacer.
`default_nettype none
package elp_pkg;

   // Event codes carried in the action field.
   typedef enum logic [1:0] {
      ACT_LOOP_START = 2'd0,
      ACT_WORK_DONE  = 2'd1,
      ACT_RECHECK    = 2'd2,
      ACT_ADVANCE    = 2'd3
   } action_type;

   localparam int ACTION_W    = 2;
   localparam int TIME_W      = 32;
   localparam int WAIT_W      = 16;
   localparam int COUNT_W     = 64;
   localparam int PERIOD_MS_W = 4;

   localparam logic [PERIOD_MS_W-1:0] PERIOD_MS_RESET = 4'd10;
   localparam logic [PERIOD_MS_W-1:0] PERIOD_MS_MIN   = 4'd1;
   localparam logic [PERIOD_MS_W-1:0] PERIOD_MS_MAX   = 4'd10;

   localparam int US_PER_MS_DEFAULT = 1000;

   // The rounded quotient numerator is one bit wider than a timestamp.
   localparam int DIV_STEPS = TIME_W + 1;
   localparam int CNT_W     = 6;

   // True when the word, read as a signed 32-bit value, is above zero.
   function automatic logic positive32(input logic [TIME_W-1:0] w);
      positive32 = (w != '0) && !w[TIME_W-1];
   endfunction

   // Saturates a 32-bit value to the 16-bit wait field.
   function automatic logic [WAIT_W-1:0] sat16(input logic [TIME_W-1:0] w);
      sat16 = (|w[TIME_W-1:WAIT_W]) ? '1 : w[WAIT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/elp_if.sv -----
// Channel interfaces of the loop pacer: event request, result response, period register write.
`default_nettype none
interface elp_req_if;
   import elp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIME_W-1:0]   timestamp_us;
   modport source (output valid, action, timestamp_us, input ready);
   modport sink   (input valid, action, timestamp_us, output ready);
endinterface

interface elp_rsp_if;
   import elp_pkg::*;
   logic               valid;
   logic               ready;
   logic [WAIT_W-1:0]  wait_us;
   logic [TIME_W-1:0]  elapsed_us;
   logic [TIME_W-1:0]  max_elapsed_us;
   logic [TIME_W-1:0]  overrun_count;
   logic [COUNT_W-1:0] loop_count;
   logic               wrap_seen;
   modport source (output valid, wait_us, elapsed_us, max_elapsed_us, overrun_count,
                   loop_count, wrap_seen, input ready);
   modport sink   (input valid, wait_us, elapsed_us, max_elapsed_us, overrun_count,
                   loop_count, wrap_seen, output ready);
endinterface

interface elp_csr_if;
   import elp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [PERIOD_MS_W-1:0] period_ms;
   modport source (output valid, period_ms, input ready);
   modport sink   (input valid, period_ms, output ready);
endinterface
`default_nettype wire

// ----- hdl/elp_alu.sv -----
// Shared add/subtract unit with an unsigned borrow flag, reused by the sequencer's arithmetic steps.
`default_nettype none
module elp_alu #(
   parameter int WIDTH = 33
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] result,
   output logic                  borrow
);
   logic             carry;
   logic [WIDTH-1:0] b_eff;

   assign b_eff           = sub ? ~b : b;
   assign {carry, result} = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
   // For a subtraction a missing carry out means a < b.
   assign borrow          = sub & ~carry;
endmodule
`default_nettype wire

// ----- hdl/epoch_anchored_loop_pacer_unit.sv -----
// Top level of the epoch anchored loop pacer: event sequencer around one shared adder.
//
// Usage: events enter on req_chan (action, timestamp_us) and every accepted transaction
// yields exactly one transaction on rsp_chan carrying the wait to apply now and the loop
// statistics. csr_chan writes the loop period in milliseconds; values outside 1..10 are
// dropped, a valid value clears the epoch and the elapsed/overrun statistics. Writes are
// meant to arrive only while no event is in flight; the port is always ready.
// Sequencing: loop start, advance and recheck go from acceptance via ST_OUT to the result
// register. Work done runs ST_DIV if the work overran the period, then ST_FIX, ST_MUL,
// ST_TGT, ST_LEFT, ST_SCALE and ST_OUT. The multiply walks the PER_W bits of the period,
// PER_W being the bit width of 10 * US_PER_MS (14 for the default). The single adder runs
// a bit-serial restoring divide for the overrun catch-up, a shift-and-add multiply of the
// loop count by the period, then the target, remaining-time and 7/8 scaling steps.
// One event is processed at a time; req_chan.ready is high only while the sequencer is
// idle. A finished result waits in the output register, so the next event may be
// accepted while the receiver stalls; the sequencer only holds in its last step when
// the output register is still occupied.
// Reset (synchronous, active high) restores a 10 ms period and zero state, with no epoch.
`default_nettype none
module epoch_anchored_loop_pacer_unit #(
   parameter int US_PER_MS = elp_pkg::US_PER_MS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   elp_req_if.sink    req_chan,
   elp_rsp_if.source  rsp_chan,
   elp_csr_if.sink    csr_chan
);
   import elp_pkg::*;

   // The period in microseconds never exceeds the largest period times US_PER_MS.
   localparam int PER_MAX = 10 * US_PER_MS;
   localparam int PER_W   = $clog2(PER_MAX + 1);
   localparam int ALU_W   = (PER_W + 1 > DIV_STEPS) ? PER_W + 1 : DIV_STEPS;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_FIX   = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_TGT   = 8'b0001_0000,
      ST_LEFT  = 8'b0010_0000,
      ST_SCALE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Architectural state.
   logic [PER_W-1:0]   per_ff, per_in;
   logic               epoch_valid_ff, epoch_valid_in;
   logic [TIME_W-1:0]  epoch_ff, epoch_in;
   logic [TIME_W-1:0]  begin_ff, begin_in;
   logic [TIME_W-1:0]  end_ff, end_in;
   logic [COUNT_W-1:0] pc_ff, pc_in;
   logic [TIME_W-1:0]  target_ff, target_in;
   logic               rp_ff, rp_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]  peak_ff, peak_in;
   logic [TIME_W-1:0]  overrun_ff, overrun_in;

   // Sequencer working registers.
   logic                 ovr_ff, ovr_in;
   logic                 wrap_ff, wrap_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_STEPS-1:0] num_ff, num_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [PER_W-1:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]    acc_ff, acc_in;
   logic [TIME_W-1:0]    mcand_ff, mcand_in;
   logic [PER_W-1:0]     mplier_ff, mplier_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WAIT_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]  rsp_elapsed_ff, rsp_elapsed_in;
   logic [TIME_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic [TIME_W-1:0]  rsp_overrun_ff, rsp_overrun_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_wrap_ff, rsp_wrap_in;

   // Shared adder.
   logic [ALU_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_sub, alu_borrow;

   elp_alu #(.WIDTH(ALU_W)) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   logic                 req_fire;
   logic                 csr_fire;
   logic                 csr_legal;
   logic [PER_W:0]       div_trial;
   logic [TIME_W-1:0]    ts_elapsed;
   logic [TIME_W-1:0]    corr;
   logic [COUNT_W-1:0]   pc_fixed;
   logic [TIME_W-1:0]    alu_word;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid & csr_chan.ready;
   assign csr_legal      = (csr_chan.period_ms >= PERIOD_MS_MIN) &&
                           (csr_chan.period_ms <= PERIOD_MS_MAX);

   assign div_trial  = {rem_ff, num_ff[DIV_STEPS-1]};
   assign ts_elapsed = req_chan.timestamp_us - begin_ff;
   assign alu_word   = alu_res[TIME_W-1:0];
   assign corr       = alu_word;

   // Operand selection for the shared adder, by sequencer step.
   always_comb begin
      alu_a   = ALU_W'(target_ff);
      alu_b   = ALU_W'(req_chan.timestamp_us);
      alu_sub = 1'b1;
      case (state_ff)
         ST_DIV: begin
            alu_a   = ALU_W'(div_trial);
            alu_b   = ALU_W'(per_ff);
            alu_sub = 1'b1;
         end
         ST_MUL: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(mcand_ff);
            alu_sub = 1'b0;
         end
         ST_TGT: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(epoch_ff);
            alu_sub = 1'b0;
         end
         ST_LEFT: begin
            alu_a   = ALU_W'(target_ff);
            alu_b   = ALU_W'(end_ff);
            alu_sub = 1'b1;
         end
         ST_SCALE: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(acc_ff >> 3);
            alu_sub = 1'b1;
         end
         default: begin
            // Idle: recheck correction, target minus the sampled timestamp.
            alu_a   = ALU_W'(target_ff);
            alu_b   = ALU_W'(req_chan.timestamp_us);
            alu_sub = 1'b1;
         end
      endcase
   end

   // Catch-up and wrap repair applied to the loop count before the target is rebuilt.
   always_comb begin
      pc_fixed = pc_ff;
      if (ovr_ff) begin
         pc_fixed = pc_ff + COUNT_W'(quo_ff) - COUNT_W'(1);
      end
      if (wrap_ff) begin
         pc_fixed = COUNT_W'(1);
      end
   end

   always_comb begin
      state_in       = state_ff;
      per_in         = per_ff;
      epoch_valid_in = epoch_valid_ff;
      epoch_in       = epoch_ff;
      begin_in       = begin_ff;
      end_in         = end_ff;
      pc_in          = pc_ff;
      target_in      = target_ff;
      rp_in          = rp_ff;
      elapsed_in     = elapsed_ff;
      peak_in        = peak_ff;
      overrun_in     = overrun_ff;
      ovr_in         = ovr_ff;
      wrap_in        = wrap_ff;
      wait_in        = wait_ff;
      cnt_in         = cnt_ff;
      num_in         = num_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_wait_in    = rsp_wait_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_peak_in    = rsp_peak_ff;
      rsp_overrun_in = rsp_overrun_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_wrap_in    = rsp_wrap_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wait_in  = '0;
               wrap_in  = 1'b0;
               state_in = ST_OUT;
               case (action_type'(req_chan.action))
                  ACT_LOOP_START: begin
                     if (!epoch_valid_ff) begin
                        epoch_valid_in = 1'b1;
                        epoch_in       = req_chan.timestamp_us;
                        begin_in       = req_chan.timestamp_us;
                        pc_in          = COUNT_W'(1);
                     end
                  end
                  ACT_WORK_DONE: begin
                     end_in     = req_chan.timestamp_us;
                     elapsed_in = ts_elapsed;
                     if (ts_elapsed > peak_ff) begin
                        peak_in = ts_elapsed;
                     end
                     // The previous end time lying after this one means the clock wrapped.
                     wrap_in = end_ff > req_chan.timestamp_us;
                     ovr_in  = ts_elapsed > TIME_W'(per_ff);
                     if (ts_elapsed > TIME_W'(per_ff)) begin
                        overrun_in = overrun_ff + TIME_W'(1);
                        // Rounded quotient: (elapsed + period/2) / period.
                        num_in     = DIV_STEPS'(ts_elapsed) + DIV_STEPS'(per_ff >> 1);
                        rem_in     = '0;
                        quo_in     = '0;
                        cnt_in     = CNT_W'(DIV_STEPS - 1);
                        state_in   = ST_DIV;
                     end else begin
                        state_in = ST_FIX;
                     end
                  end
                  ACT_RECHECK: begin
                     if (rp_ff && positive32(corr) && (corr < TIME_W'(per_ff))) begin
                        wait_in = sat16(corr);
                     end
                  end
                  default: begin
                     begin_in = req_chan.timestamp_us;
                     pc_in    = pc_ff + COUNT_W'(1);
                  end
               endcase
            end
         end
         ST_DIV: begin
            // One restoring divide step per cycle, quotient bit shifted in from the right.
            rem_in = alu_borrow ? div_trial[PER_W-1:0] : alu_res[PER_W-1:0];
            quo_in = {quo_ff[DIV_STEPS-2:0], ~alu_borrow};
            num_in = num_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            pc_in = pc_fixed;
            if (wrap_ff) begin
               epoch_in = begin_ff;
            end
            acc_in    = '0;
            mcand_in  = pc_fixed[TIME_W-1:0];
            mplier_in = per_ff;
            cnt_in    = CNT_W'(PER_W - 1);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // Shift-and-add multiply of the loop count by the period, modulo 2^32.
            if (mplier_ff[0]) begin
               acc_in = alu_word;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            target_in = alu_word;
            state_in  = ST_LEFT;
         end
         ST_LEFT: begin
            acc_in   = alu_word;
            rp_in    = positive32(alu_word);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            wait_in  = rp_ff ? sat16(alu_word) : '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_wait_in    = wait_ff;
               rsp_elapsed_in = elapsed_ff;
               rsp_peak_in    = peak_ff;
               rsp_overrun_in = overrun_ff;
               rsp_count_in   = pc_ff;
               rsp_wrap_in    = wrap_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A legal period write restarts the epoch and clears the statistics.
      if (csr_fire && csr_legal) begin
         per_in         = PER_W'(csr_chan.period_ms * US_PER_MS);
         epoch_valid_in = 1'b0;
         elapsed_in     = '0;
         peak_in        = '0;
         overrun_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         per_ff         <= PER_W'(PERIOD_MS_RESET * US_PER_MS);
         epoch_valid_ff <= 1'b0;
         epoch_ff       <= '0;
         begin_ff       <= '0;
         end_ff         <= '0;
         pc_ff          <= '0;
         target_ff      <= '0;
         rp_ff          <= 1'b0;
         elapsed_ff     <= '0;
         peak_ff        <= '0;
         overrun_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         per_ff         <= per_in;
         epoch_valid_ff <= epoch_valid_in;
         epoch_ff       <= epoch_in;
         begin_ff       <= begin_in;
         end_ff         <= end_in;
         pc_ff          <= pc_in;
         target_ff      <= target_in;
         rp_ff          <= rp_in;
         elapsed_ff     <= elapsed_in;
         peak_ff        <= peak_in;
         overrun_ff     <= overrun_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovr_ff         <= ovr_in;
      wrap_ff        <= wrap_in;
      wait_ff        <= wait_in;
      cnt_ff         <= cnt_in;
      num_ff         <= num_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      acc_ff         <= acc_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_overrun_ff <= rsp_overrun_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_wrap_ff    <= rsp_wrap_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.wait_us        = rsp_wait_ff;
   assign rsp_chan.elapsed_us     = rsp_elapsed_ff;
   assign rsp_chan.max_elapsed_us = rsp_peak_ff;
   assign rsp_chan.overrun_count  = rsp_overrun_ff;
   assign rsp_chan.loop_count     = rsp_count_ff;
   assign rsp_chan.wrap_seen      = rsp_wrap_ff;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench of the loop pacer: a directed event table, then paced loops and noise.
`timescale 1ns / 1ps
module tb_top;
   import elp_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 8;
   localparam int PHASE_EVENTS  = 219;   // about 1750 random events over all phases
   localparam int DRAIN_CYCLES  = 60;    // longest work-done latency with an overrun, plus margin
   localparam int DIRECTED_ROWS = 21;
   localparam logic [63:0] WRAP_SPAN = 64'h1_0000_0000;

   typedef struct packed {
      logic [WAIT_W-1:0]  wait_us;
      logic [TIME_W-1:0]  elapsed_us;
      logic [TIME_W-1:0]  max_elapsed_us;
      logic [TIME_W-1:0]  overrun_count;
      logic [COUNT_W-1:0] loop_count;
      logic               wrap_seen;
   } pacer_result_type;

   // One directed event. Rows marked typed carry their result by hand; the rest are
   // checked against the pacing predictor below.
   typedef struct {
      action_type        act;
      logic [TIME_W-1:0] stamp;
      bit                typed;
      pacer_result_type  result;
   } event_row_type;

   logic clock;
   logic reset;

   elp_req_if req_if ();
   elp_rsp_if rsp_if ();
   elp_csr_if csr_if ();

   epoch_anchored_loop_pacer_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // The walk below runs at the reset period of 10 ms. It covers events before any
   // loop start, a repeated loop start, rechecks on both sides of the target, an
   // overrun with rounded catch-up, both kinds of wrap-around repair and the largest
   // possible elapsed time.
   event_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_RECHECK,    32'h0000_0000, 1'b1, '0},
      '{ACT_ADVANCE,    32'hFFFF_FFFF, 1'b1, {16'd0, 32'd0, 32'd0, 32'd0, 64'd1, 1'b0}},
      '{ACT_WORK_DONE,  32'h0000_0000, 1'b0, '0},
      '{ACT_LOOP_START, 32'd1000,      1'b0, '0},
      '{ACT_LOOP_START, 32'd5000,      1'b0, '0},
      '{ACT_WORK_DONE,  32'd3000,      1'b0, '0},
      '{ACT_RECHECK,    32'd9000,      1'b0, '0},
      '{ACT_RECHECK,    32'd10999,     1'b0, '0},
      '{ACT_RECHECK,    32'd11000,     1'b0, '0},
      '{ACT_RECHECK,    32'd20000,     1'b0, '0},
      '{ACT_ADVANCE,    32'd11000,     1'b0, '0},
      '{ACT_WORK_DONE,  32'd46000,     1'b0, '0},
      '{ACT_RECHECK,    32'h0000_0000, 1'b0, '0},
      '{ACT_WORK_DONE,  32'd11001,     1'b0, '0},
      '{ACT_ADVANCE,    32'hFFFF_0000, 1'b0, '0},
      '{ACT_WORK_DONE,  32'h0000_0100, 1'b0, '0},
      '{ACT_WORK_DONE,  32'h0000_0200, 1'b0, '0},
      '{ACT_RECHECK,    32'h0000_0300, 1'b0, '0},
      '{ACT_ADVANCE,    32'd5,         1'b0, '0},
      '{ACT_WORK_DONE,  32'd4,         1'b0, '0},
      '{ACT_RECHECK,    32'hFFFF_FFFF, 1'b0, '0}
   };

   // Period settings per random phase; 0, 15 and 11 are out of range and must be dropped.
   logic [PERIOD_MS_W-1:0] period_plan [PHASES] = '{
      PERIOD_MS_MIN, PERIOD_MS_MAX, 4'd0, 4'd5, 4'd15, 4'd3, 4'd11, 4'd8
   };

   // Shadow copy of the pacer state.
   logic [PERIOD_MS_W-1:0] shadow_period_ms;
   logic                   shadow_epoch_valid;
   logic [63:0]            shadow_epoch;
   logic [63:0]            shadow_count;
   logic [63:0]            shadow_target;
   logic [TIME_W-1:0]      shadow_begin;
   logic [TIME_W-1:0]      shadow_end;
   logic [TIME_W-1:0]      shadow_prev_end;
   logic [TIME_W-1:0]      shadow_elapsed;
   logic [TIME_W-1:0]      shadow_peak;
   logic [TIME_W-1:0]      shadow_overruns;
   logic                   shadow_time_left;

   pacer_result_type pending_results [$];
   pacer_result_type observed;
   pacer_result_type wanted;
   logic [TIME_W-1:0] loop_clock;
   int unsigned events_sent;
   int unsigned fail_count;
   int unsigned cycle_count;
   bit calm;

   // Applies one event to the shadow state and returns the result it must produce.
   function automatic pacer_result_type pace_event(input action_type act,
                                                   input logic [TIME_W-1:0] stamp);
      logic [63:0]       span_us;
      logic [63:0]       diff;
      logic [63:0]       stamp_ext;
      logic [TIME_W-1:0] left;
      pacer_result_type  res;
      span_us = 64'(shadow_period_ms) * 64'(US_PER_MS_DEFAULT);
      res = '0;
      case (act)
         ACT_LOOP_START: begin
            // The epoch is anchored only once until a period write clears it.
            if (!shadow_epoch_valid) begin
               shadow_epoch_valid = 1'b1;
               shadow_epoch       = 64'(stamp);
               shadow_begin       = stamp;
               shadow_count       = 64'd1;
            end
         end
         ACT_WORK_DONE: begin
            shadow_prev_end = shadow_end;
            shadow_end      = stamp;
            shadow_elapsed  = shadow_end - shadow_begin;
            if (shadow_elapsed > shadow_peak) shadow_peak = shadow_elapsed;
            if (64'(shadow_elapsed) > span_us) begin
               // Catch up by the rounded number of periods the work took.
               shadow_overruns = shadow_overruns + 1;
               shadow_count = shadow_count + (64'(shadow_elapsed) + span_us / 2) / span_us - 1;
            end
            if (shadow_prev_end > shadow_end) begin
               // The timestamp wrapped since the last work done: re-anchor on this loop.
               shadow_epoch = (shadow_begin > shadow_end) ? 64'(shadow_begin) - WRAP_SPAN
                                                          : 64'(shadow_begin);
               shadow_count  = 64'd1;
               res.wrap_seen = 1'b1;
            end
            shadow_target    = shadow_count * span_us + shadow_epoch;
            diff             = shadow_target - 64'(shadow_end);
            shadow_time_left = (diff[31:0] != '0) && !diff[31];
            if (shadow_time_left) begin
               left        = diff[31:0] - (diff[31:0] >> 3);
               res.wait_us = (left[31:16] != '0) ? '1 : left[15:0];
            end
         end
         ACT_RECHECK: begin
            if (shadow_time_left) begin
               stamp_ext = 64'(stamp);
               if (stamp < shadow_end) stamp_ext = stamp_ext + WRAP_SPAN;
               diff = shadow_target - stamp_ext;
               if ((diff[31:0] != '0) && !diff[31] && (64'(diff[31:0]) < span_us)) begin
                  res.wait_us = (diff[31:16] != '0) ? '1 : diff[15:0];
               end
            end
         end
         default: begin
            shadow_begin = stamp;
            shadow_count = shadow_count + 1;
         end
      endcase
      res.elapsed_us     = shadow_elapsed;
      res.max_elapsed_us = shadow_peak;
      res.overrun_count  = shadow_overruns;
      res.loop_count     = shadow_count;
      return res;
   endfunction

   // Offers one event and records its expected result once the transaction is taken.
   // The valid is only lowered inside a gap, so back-to-back events keep it high.
   task automatic send_event(input action_type act, input logic [TIME_W-1:0] stamp,
                             input bit typed = 1'b0, input pacer_result_type given = '0);
      pacer_result_type predicted;
      if (!calm) begin
         while ($urandom_range(0, 99) < 36) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.timestamp_us <= stamp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = pace_event(act, stamp);
      pending_results.push_back(typed ? given : predicted);
      events_sent++;
   endtask

   // Writes the period once every result of the previous phase has come back.
   task automatic write_period(input logic [PERIOD_MS_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.period_ms <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (value >= PERIOD_MS_MIN && value <= PERIOD_MS_MAX) begin
         shadow_period_ms   = value;
         shadow_epoch_valid = 1'b0;
         shadow_elapsed     = '0;
         shadow_peak        = '0;
         shadow_overruns    = '0;
      end
   endtask

   // One well-formed loop: optional start, work done, up to three rechecks, then advance.
   // Work times are mostly inside the period, with overruns and near-zero work mixed in.
   task automatic run_paced_loop();
      int unsigned span;
      int unsigned work;
      span = shadow_period_ms * US_PER_MS_DEFAULT;
      if (!shadow_epoch_valid || $urandom_range(0, 19) == 0) begin
         send_event(ACT_LOOP_START, loop_clock);
      end
      case ($urandom_range(0, 9))
         0, 1: begin
            work = span + $urandom_range(1, 4 * span);
         end
         2: begin
            work = $urandom_range(0, 2);
         end
         default: begin
            work = $urandom_range(0, span);
         end
      endcase
      loop_clock = loop_clock + work;
      send_event(ACT_WORK_DONE, loop_clock);
      repeat ($urandom_range(0, 3)) begin
         send_event(ACT_RECHECK, loop_clock + $urandom_range(0, span + span / 4));
      end
      loop_clock = loop_clock + $urandom_range(0, span);
      send_event(ACT_ADVANCE, loop_clock);
   endtask

   always #5 clock = ~clock;

   // Result side: random back-pressure, and every result checked against the oldest
   // expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            observed = {rsp_if.wait_us, rsp_if.elapsed_us, rsp_if.max_elapsed_us,
                        rsp_if.overrun_count, rsp_if.loop_count, rsp_if.wrap_seen};
            if (pending_results.size() == 0) begin
               $error("result transaction with no event awaiting a result");
               fail_count++;
            end else begin
               wanted = pending_results.pop_front();
               if (observed.wait_us !== wanted.wait_us) begin
                  $error("wait_us: expected %0d, actual %0d", wanted.wait_us, observed.wait_us);
                  fail_count++;
               end
               if (observed.elapsed_us !== wanted.elapsed_us) begin
                  $error("elapsed_us: expected %0d, actual %0d",
                         wanted.elapsed_us, observed.elapsed_us);
                  fail_count++;
               end
               if (observed.max_elapsed_us !== wanted.max_elapsed_us) begin
                  $error("max_elapsed_us: expected %0d, actual %0d",
                         wanted.max_elapsed_us, observed.max_elapsed_us);
                  fail_count++;
               end
               if (observed.overrun_count !== wanted.overrun_count) begin
                  $error("overrun_count: expected %0d, actual %0d",
                         wanted.overrun_count, observed.overrun_count);
                  fail_count++;
               end
               if (observed.loop_count !== wanted.loop_count) begin
                  $error("loop_count: expected %0d, actual %0d",
                         wanted.loop_count, observed.loop_count);
                  fail_count++;
               end
               if (observed.wrap_seen !== wanted.wrap_seen) begin
                  $error("wrap_seen: expected %0d, actual %0d",
                         wanted.wrap_seen, observed.wrap_seen);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= 36);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run timed out after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int ph;
      int unsigned phase_start;
      clock               = 1'b0;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.action       = ACT_LOOP_START;
      req_if.timestamp_us = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.period_ms    = PERIOD_MS_RESET;
      shadow_period_ms    = PERIOD_MS_RESET;
      shadow_epoch_valid  = 1'b0;
      shadow_epoch        = '0;
      shadow_count        = '0;
      shadow_target       = '0;
      shadow_begin        = '0;
      shadow_end          = '0;
      shadow_prev_end     = '0;
      shadow_elapsed      = '0;
      shadow_peak         = '0;
      shadow_overruns     = '0;
      shadow_time_left    = 1'b0;
      loop_clock          = '0;
      events_sent         = 0;
      fail_count          = 0;
      cycle_count         = 0;
      calm                = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_event(directed_rows[i].act, directed_rows[i].stamp,
                    directed_rows[i].typed, directed_rows[i].result);
      end

      // Random phases. Each phase has an even chance to start the loop clock just below the wrap
      // point so that wrap-around repair is reached often; one phase runs without any idling.
      for (ph = 0; ph < PHASES; ph++) begin
         write_period(period_plan[ph]);
         calm        = (ph == 3);
         loop_clock  = $urandom_range(0, 1) ? $urandom()
                                            : 32'hFFFF_FFFF - $urandom_range(0, 300_000);
         phase_start = events_sent;
         while (events_sent - phase_start < PHASE_EVENTS) begin
            if ($urandom_range(0, 99) < 80) begin
               run_paced_loop();
            end else begin
               send_event(action_type'($urandom_range(0, 3)), $urandom());
            end
         end
      end

      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/elp_pkg.sv
hdl/elp_if.sv
hdl/elp_alu.sv
hdl/epoch_anchored_loop_pacer_unit.sv
verif/tb_top.sv
